@@ sv/bis_pkg.sv @@
`timescale 1ns / 1ps

package bis_pkg;

	// Width of the key ports, fixed by the interface.
	localparam int KEY_PORT_W = 32;

	// Defaults for the top-level parameters.
	localparam int MAX_KEYS_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SWAIT,
		ST_SHIFT,
		ST_INSERT,
		ST_OUT_RD,
		ST_OUT_LD
	} bis_state_t;

endpackage

@@ sv/bis_store.sv @@
`timescale 1ns / 1ps

module bis_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	import bis_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// The read data register holds its value until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/binary_insertion_sorter_core.sv @@
`timescale 1ns / 1ps
// Insertion of one key with n keys held: a binary search over the held keys (one store
// read and one compare per step), then each larger key is moved up one place, then the key
// is written; the single read port of the store sets the pace. After the last key of a
// set, each result is read and loaded into the output register once the output is free,
// before the next is read. Reset clears the state machine, the fill count, the drop flag
// and the output valid; the key store is not cleared, as only held entries are read.
module binary_insertion_sorter_core #(
	parameter int MAX_KEYS  = bis_pkg::MAX_KEYS_DEF,
	parameter int KEY_WIDTH = bis_pkg::KEY_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [bis_pkg::KEY_PORT_W-1:0] key,
	input  logic                           last_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [bis_pkg::KEY_PORT_W-1:0] sorted_key,
	output logic                           last_out,
	output logic                           overflow
);
	import bis_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	bis_state_t state_q, state_d;

	logic [KEY_WIDTH-1:0] key_in_w;
	logic [KEY_WIDTH-1:0] key_q;
	logic                 last_q;
	logic [CW-1:0]        fill_q;
	logic                 dropped_q;
	logic [CW-1:0]        lo_q, hi_q, idx_q, oidx_q;
	logic [CW-1:0]        mid_w;

	logic                 mv_s1;
	logic [AW-1:0]        mv_addr_s1;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [KEY_WIDTH-1:0] rd_data;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;

	logic                 accept;
	logic                 ld_out;
	logic                 out_last_w;
	logic                 full_w;
	logic                 greater_w;
	logic [KEY_PORT_W-1:0] rd_key_w;

	logic                  out_valid_q;
	logic [KEY_PORT_W-1:0] out_key_q;
	logic                  out_last_q;
	logic                  out_ovf_q;

	// Only the low KEY_WIDTH bits of the key count; bit KEY_WIDTH-1 is the sign.
	generate
		if (KEY_WIDTH <= KEY_PORT_W) begin : g_in_narrow
			assign key_in_w = key[KEY_WIDTH-1:0];
		end else begin : g_in_wide
			assign key_in_w = {{(KEY_WIDTH - KEY_PORT_W){1'b0}}, key};
		end
		if (KEY_WIDTH >= KEY_PORT_W) begin : g_out_wide
			assign rd_key_w = rd_data[KEY_PORT_W-1:0];
		end else begin : g_out_narrow
			assign rd_key_w = {{(KEY_PORT_W - KEY_WIDTH){1'b0}}, rd_data};
		end
	endgenerate

	assign mid_w      = lo_q + ((hi_q - lo_q) >> 1);
	assign full_w     = (fill_q == CW'(MAX_KEYS));
	assign greater_w  = ($signed(rd_data) > $signed(key_q));
	assign out_last_w = ((oidx_q + CW'(1)) == fill_q);

	always_comb begin
		state_d = state_q;
		accept  = 1'b0;
		ld_out  = 1'b0;
		rd_en   = 1'b0;
		rd_addr = mid_w[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				accept = in_valid;
				if (in_valid) begin
					if (full_w) begin
						state_d = last_in ? ST_OUT_RD : ST_IDLE;
					end else begin
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (lo_q < hi_q) begin
					rd_en   = 1'b1;
					state_d = ST_SWAIT;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_SWAIT: begin
				state_d = ST_SEARCH;
			end
			ST_SHIFT: begin
				// Read below idx while the previous move is written one place up.
				rd_addr = AW'(idx_q - CW'(1));
				if (idx_q > lo_q) begin
					rd_en = 1'b1;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				state_d = last_q ? ST_OUT_RD : ST_IDLE;
			end
			ST_OUT_RD: begin
				rd_en   = 1'b1;
				rd_addr = oidx_q[AW-1:0];
				state_d = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				ld_out = !out_valid_q || !out_stall;
				if (ld_out) begin
					state_d = out_last_w ? ST_IDLE : ST_OUT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			dropped_q <= 1'b0;
			mv_s1     <= 1'b0;
		end else begin
			mv_s1 <= (state_q == ST_SHIFT) && (idx_q > lo_q);
			if (accept && full_w) begin
				dropped_q <= 1'b1;
			end
			if (state_q == ST_INSERT) begin
				fill_q <= fill_q + CW'(1);
			end
			if (ld_out && out_last_w) begin
				fill_q    <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	// Key and last flag, search bounds, move index and output index.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key_in_w;
			last_q <= last_in;
			lo_q   <= '0;
			hi_q   <= fill_q;
			oidx_q <= '0;
		end
		if (state_q == ST_SEARCH) begin
			idx_q <= fill_q;
		end
		if (state_q == ST_SWAIT) begin
			if (greater_w) begin
				hi_q <= mid_w;
			end else begin
				lo_q <= mid_w + CW'(1);
			end
		end
		if (state_q == ST_SHIFT && rd_en) begin
			idx_q <= idx_q - CW'(1);
		end
		mv_addr_s1 <= idx_q[AW-1:0];
		if (state_q == ST_INSERT) begin
			oidx_q <= '0;
		end
		if (ld_out) begin
			oidx_q <= oidx_q + CW'(1);
		end
	end

	assign wr_en   = mv_s1 || (state_q == ST_INSERT);
	assign wr_addr = mv_s1 ? mv_addr_s1 : lo_q[AW-1:0];
	assign wr_data = mv_s1 ? rd_data : key_q;

	bis_store #(
		.DEPTH(MAX_KEYS),
		.WIDTH(KEY_WIDTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Output register: a finished item waits here while the next key is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_key_q  <= rd_key_w;
			out_last_q <= out_last_w;
			out_ovf_q  <= dropped_q;
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sorted_key = out_key_q;
	assign last_out   = out_last_q;
	assign overflow   = out_ovf_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_KEYS))
		else $error("fill count beyond store depth");

	a_search_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWAIT |-> lo_q < hi_q)
		else $error("search read with an empty interval");

	a_shift_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> idx_q >= lo_q && idx_q <= fill_q)
		else $error("move index outside insertion range");

	a_insert_port: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INSERT |-> !mv_s1)
		else $error("insert write collides with a pending move");

	a_set_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out && out_last_w |=> fill_q == '0 && !dropped_q && out_valid_q)
		else $error("set not cleared after its last item");

endmodule

@@ dv/binary_insertion_sorter_core_test.sv @@
`timescale 1ns / 1ps

module binary_insertion_sorter_core_test;
	import bis_pkg::*;

	localparam int STORE_DEPTH = MAX_KEYS_DEF;
	localparam int HOLD_CYCLES = 700;
	localparam int QUIET_LIMIT = 6000;
	localparam int END_WAIT    = 300;

	typedef logic signed [KEY_PORT_W-1:0] key_t;

	typedef struct packed {
		key_t key;
		logic last;
	} key_item_t;

	typedef struct packed {
		key_t sorted_key;
		logic last_out;
		logic overflow;
	} sorted_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	key_t key = '0;
	logic last_in = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	key_t sorted_key;
	logic last_out;
	logic overflow;

	binary_insertion_sorter_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key(key),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sorted_key(sorted_key),
		.last_out(last_out),
		.overflow(overflow)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	key_item_t pending_keys[$];
	sorted_res_t sorted_expect[$];

	// Our own copy of the sorted set being collected.
	key_t held_keys[STORE_DEPTH];
	int held_count = 0;
	bit keys_dropped = 1'b0;

	int send_idle_pct = 18;
	int recv_idle_pct = 71;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int keys_accepted = 0;
	int keys_retired = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	sorted_res_t want_res;
	key_item_t next_item;
	bit moved;

	// Upper-bound insertion, so equal keys keep their arrival order.
	task automatic absorb_key(input key_t k, input logic fin);
		int lo;
		int hi;
		int mid;
		int i;
		sorted_res_t r;
		if (held_count < STORE_DEPTH) begin
			lo = 0;
			hi = held_count;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if ($signed(held_keys[mid]) > $signed(k))
					hi = mid;
				else
					lo = mid + 1;
			end
			for (i = held_count; i > lo; i--)
				held_keys[i] = held_keys[i - 1];
			held_keys[lo] = k;
			held_count++;
		end else begin
			keys_dropped = 1'b1;
		end
		if (fin) begin
			for (i = 0; i < held_count; i++) begin
				r.sorted_key = held_keys[i];
				r.last_out = (i == held_count - 1);
				r.overflow = keys_dropped;
				sorted_expect.push_back(r);
			end
			held_count = 0;
			keys_dropped = 1'b0;
		end
	endtask

	function automatic key_t rand_key();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2, 3: return $urandom;
			4, 5: return $urandom_range(8) - 4;
			6: begin
				case ($urandom_range(3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom_range(2000) - 1000;
		endcase
	endfunction

	task automatic queue_key(input key_t k, input logic fin);
		key_item_t it;
		it.key = k;
		it.last = fin;
		pending_keys.push_back(it);
	endtask

	task automatic queue_set(input int n);
		int i;
		for (i = 0; i < n; i++)
			queue_key(rand_key(), i == n - 1);
	endtask

	// Random sets of small size until the phase holds about target keys.
	task automatic queue_small_sets(input int target);
		int queued;
		int n;
		queued = 0;
		while (queued < target) begin
			n = $urandom_range(12, 1);
			queue_set(n);
			queued += n;
		end
	endtask

	task automatic wait_drained();
		while (pending_keys.size() != 0 || in_valid || sorted_expect.size() != 0)
			@(posedge clk);
	endtask

	// Sender: an offered item stays put until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || keys_accepted != keys_retired) begin
				keys_retired = keys_accepted;
				if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_keys.pop_front();
					in_valid <= 1'b1;
					key <= next_item.key;
					last_in <= next_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver, with a long hold-off on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				keys_accepted++;
				absorb_key(key, last_in);
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (sorted_expect.size() == 0) begin
					$error("unexpected result: sorted_key %0d", sorted_key);
					error_count++;
				end else begin
					want_res = sorted_expect.pop_front();
					if (sorted_key !== want_res.sorted_key) begin
						$error("sorted_key: expected %0d, got %0d", want_res.sorted_key,
							sorted_key);
						error_count++;
					end
					if (last_out !== want_res.last_out) begin
						$error("last_out: expected %0b, got %0b", want_res.last_out, last_out);
						error_count++;
					end
					if (overflow !== want_res.overflow) begin
						$error("overflow: expected %0b, got %0b", want_res.overflow, overflow);
						error_count++;
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Extremes, alternating bit patterns and repeated keys in one set.
		queue_key(32'sh7fffffff, 1'b0);
		queue_key(32'sh80000000, 1'b0);
		queue_key(0, 1'b0);
		queue_key(-1, 1'b0);
		queue_key(1, 1'b0);
		queue_key(32'sh55555555, 1'b0);
		queue_key(32'shaaaaaaaa, 1'b0);
		queue_key(5, 1'b0);
		queue_key(5, 1'b0);
		queue_key(5, 1'b0);
		queue_key(32'sh80000000, 1'b0);
		queue_key(32'sh7fffffff, 1'b1);
		// A set of one key, then descending and short sets.
		queue_key(-7, 1'b1);
		queue_key(3, 1'b0);
		queue_key(2, 1'b0);
		queue_key(1, 1'b0);
		queue_key(1, 1'b0);
		queue_key(0, 1'b1);
		queue_key(-100, 1'b0);
		queue_key(100, 1'b1);

		// A set that fills the store exactly.
		queue_set(STORE_DEPTH);
		queue_small_sets(30);
		wait_drained();

		send_idle_pct = 71;
		recv_idle_pct = 18;
		queue_small_sets(25);
		// Two keys beyond a full store; the dropped final key still starts the output.
		queue_set(STORE_DEPTH + 2);
		queue_small_sets(30);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		queue_small_sets(130);
		wait_drained();

		repeat (END_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
